[rtl/core/rdc_pkg.sv]
// Shared types and constants of the rotation direction classifier.
// Holds the direction codes, configuration register layout and reset values.
// Depends on nothing.
package rdc_pkg;

  localparam int unsigned YawW = 16;
  localparam int unsigned CntW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 15;

  typedef enum logic [1:0] {
    DirUnknown = 2'd0,
    DirStable = 2'd1,
    DirAnticlockwise = 2'd2,
    DirClockwise = 2'd3
  } dir_e;

  localparam logic [CfgIdxW-1:0] CfgSampleCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCompareLag = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgJumpThreshold = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgStableThreshold = 2'd3;

  localparam logic [7:0] SampleCountRst = 8'd20;
  localparam logic [4:0] CompareLagRst = 5'd1;
  localparam logic [14:0] JumpThresholdRst = 15'd8192;
  localparam logic [14:0] StableThresholdRst = 15'd100;

  typedef struct packed {
    logic [7:0] sample_count;
    logic [4:0] compare_lag;
    logic [14:0] jump_threshold;
    logic [14:0] stable_threshold;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic [YawW-1:0] data;
  } hist_wr_t;

endpackage

[rtl/core/rdc_history.sv]
// Yaw sample history of the rotation direction classifier.
// One write port and one read port over a small register array.
// Depends on rdc_pkg.
module rdc_history #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                  clk_i,
  input  rdc_pkg::hist_wr_t     wr_i,
  input  logic [AddrW-1:0]      wr_addr_i,
  input  logic [AddrW-1:0]      rd_addr_i,
  output logic [rdc_pkg::YawW-1:0] rd_data_o
);

  logic [rdc_pkg::YawW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_i] <= wr_i.data;
    end
  end

  assign rd_data_o = mem_q[rd_addr_i];

endmodule

[rtl/core/rdc_window.sv]
// Voting window and direction state of the rotation direction classifier.
// Casts at most one vote per sample, counts votes and decides at the end of a window.
// Depends on rdc_pkg and rdc_history.
module rdc_window #(
  parameter int unsigned MAX_LAG = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rdc_pkg::cfg_t            cfg_i,
  input  logic                     step_i,
  input  logic                     action_i,
  input  logic [rdc_pkg::YawW-1:0] yaw_i,
  output rdc_pkg::dir_e            dir_o,
  output logic                     decided_o
);

  localparam int unsigned PW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int unsigned LW = ($clog2(MAX_LAG + 1) > 5) ? $clog2(MAX_LAG + 1) : 5;
  localparam int unsigned CW = (LW > rdc_pkg::CntW) ? LW : rdc_pkg::CntW;
  localparam int unsigned AW = LW + 1;

  rdc_pkg::dir_e dir_q, dir_d;
  logic [rdc_pkg::CntW-1:0] samples_q, samples_d;
  logic [rdc_pkg::CntW-1:0] anti_q, anti_d;
  logic [rdc_pkg::CntW-1:0] cw_q, cw_d;
  logic [rdc_pkg::CntW-1:0] stab_q, stab_d;
  logic [PW-1:0] wptr_q, wptr_d;

  logic [LW-1:0] lag;
  logic [AW-1:0] rd_sum;
  logic [PW-1:0] rd_addr;
  logic [rdc_pkg::YawW-1:0] rd_data;
  logic [rdc_pkg::YawW-1:0] earlier;
  logic [rdc_pkg::YawW-1:0] diff;
  logic [rdc_pkg::YawW-1:0] mag;
  logic do_vote, jump, vote_anti, vote_cw, vote_stab;
  logic [rdc_pkg::CntW-1:0] need, samples_n, anti_n, cw_n, stab_n;
  logic locked, decide;
  rdc_pkg::hist_wr_t hist_wr;

  assign locked = dir_q[1];

  always_comb begin
    if (LW'(cfg_i.compare_lag) > LW'(MAX_LAG)) begin
      lag = LW'(MAX_LAG);
    end else begin
      lag = LW'(cfg_i.compare_lag);
    end
  end

  always_comb begin
    if (AW'(wptr_q) < AW'(lag)) begin
      rd_sum = AW'(wptr_q) + AW'(MAX_LAG) - AW'(lag);
    end else begin
      rd_sum = AW'(wptr_q) - AW'(lag);
    end
  end
  assign rd_addr = rd_sum[PW-1:0];

  assign hist_wr.en = step_i && !action_i && !locked;
  assign hist_wr.data = yaw_i;

  rdc_history #(
    .Depth(MAX_LAG),
    .AddrW(PW)
  ) u_history (
    .clk_i    (clk_i),
    .wr_i     (hist_wr),
    .wr_addr_i(wptr_q),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign do_vote = (lag == '0) || (CW'(samples_q) >= CW'(lag));
  assign earlier = (lag == '0) ? yaw_i : rd_data;
  assign diff = yaw_i - earlier;
  assign mag = diff[rdc_pkg::YawW-1] ? (~diff + 16'd1) : diff;
  assign jump = mag > {1'b0, cfg_i.jump_threshold};
  assign vote_anti = do_vote && !jump && !diff[rdc_pkg::YawW-1] &&
                     (mag > {1'b0, cfg_i.stable_threshold});
  assign vote_cw = do_vote && !jump && diff[rdc_pkg::YawW-1] &&
                   (mag > {1'b0, cfg_i.stable_threshold});
  assign vote_stab = do_vote && !jump && !vote_anti && !vote_cw;

  assign need = (cfg_i.sample_count == '0) ? 8'd1 : cfg_i.sample_count;
  assign samples_n = samples_q + 8'd1;
  assign anti_n = anti_q + {7'd0, vote_anti};
  assign cw_n = cw_q + {7'd0, vote_cw};
  assign stab_n = stab_q + {7'd0, vote_stab};
  assign decide = samples_n >= need;

  always_comb begin
    dir_d = dir_q;
    samples_d = samples_q;
    anti_d = anti_q;
    cw_d = cw_q;
    stab_d = stab_q;
    wptr_d = wptr_q;
    decided_o = 1'b0;
    if (action_i) begin
      dir_d = rdc_pkg::DirUnknown;
      samples_d = '0;
      anti_d = '0;
      cw_d = '0;
      stab_d = '0;
      wptr_d = '0;
    end else if (!locked) begin
      if (decide) begin
        decided_o = 1'b1;
        samples_d = '0;
        anti_d = '0;
        cw_d = '0;
        stab_d = '0;
        wptr_d = '0;
        if (anti_n > cw_n && anti_n > stab_n) begin
          dir_d = rdc_pkg::DirAnticlockwise;
        end else if (cw_n > anti_n && cw_n > stab_n) begin
          dir_d = rdc_pkg::DirClockwise;
        end else if (cw_n == anti_n) begin
          dir_d = rdc_pkg::DirUnknown;
        end else begin
          dir_d = rdc_pkg::DirStable;
        end
      end else begin
        samples_d = samples_n;
        anti_d = anti_n;
        cw_d = cw_n;
        stab_d = stab_n;
        if (32'(wptr_q) == MAX_LAG - 1) begin
          wptr_d = '0;
        end else begin
          wptr_d = wptr_q + PW'(1);
        end
      end
    end
  end

  assign dir_o = dir_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= rdc_pkg::DirUnknown;
      samples_q <= '0;
      anti_q <= '0;
      cw_q <= '0;
      stab_q <= '0;
      wptr_q <= '0;
    end else if (step_i) begin
      dir_q <= dir_d;
      samples_q <= samples_d;
      anti_q <= anti_d;
      cw_q <= cw_d;
      stab_q <= stab_d;
      wptr_q <= wptr_d;
    end
  end

  a_locked_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked |-> (samples_q == '0 && anti_q == '0 && cw_q == '0 && stab_q == '0))
    else $error("locked direction with open window");

  a_votes_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (10'(anti_q) + 10'(cw_q) + 10'(stab_q)) <= 10'(samples_q))
    else $error("more votes than samples");

  a_reset_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && action_i) |=> (dir_q == rdc_pkg::DirUnknown && samples_q == '0))
    else $error("reset item did not clear direction");

  a_wptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(wptr_q) < MAX_LAG) && (samples_q != '0 || wptr_q == '0))
    else $error("history pointer out of step with sample count");

endmodule

[rtl/core/rotation_direction_classifier.sv]
// Top level of the rotation direction classifier.
// Input stage, configuration registers and result register around rdc_window.
// Depends on rdc_pkg and rdc_window.

// Classifies spin direction from a stream of 16-bit binary yaw angles and
// returns one result per input item. The block takes one item every cycle
// while the result side does not stall: an item is held in the input register,
// then the window state and the result register update together from it, so
// the vote, count and decision for an item are combinational between the input
// and result registers. Stall on the result side backs up into the input stall.
// Write configuration only while no item is in flight.
module rotation_direction_classifier #(
  parameter int unsigned MAX_LAG = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [rdc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rdc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic signed [15:0]          yaw_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  direction_o,
  output logic                        decided_o,
  output logic                        locked_o
);

  rdc_pkg::cfg_t cfg_q;

  logic in_valid_q;
  logic action_q;
  logic [rdc_pkg::YawW-1:0] yaw_q;
  logic out_valid_q;
  logic [1:0] direction_q;
  logic decided_q;

  logic out_ready, adv, in_xfer;
  rdc_pkg::dir_e dir;
  logic decided;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_count <= rdc_pkg::SampleCountRst;
      cfg_q.compare_lag <= rdc_pkg::CompareLagRst;
      cfg_q.jump_threshold <= rdc_pkg::JumpThresholdRst;
      cfg_q.stable_threshold <= rdc_pkg::StableThresholdRst;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        rdc_pkg::CfgSampleCount: cfg_q.sample_count <= cfg_data_i[7:0];
        rdc_pkg::CfgCompareLag: cfg_q.compare_lag <= cfg_data_i[4:0];
        rdc_pkg::CfgJumpThreshold: cfg_q.jump_threshold <= cfg_data_i;
        rdc_pkg::CfgStableThreshold: cfg_q.stable_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;
  assign adv = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_xfer = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= action_i;
      yaw_q <= yaw_i;
    end
    if (adv) begin
      direction_q <= dir;
      decided_q <= decided;
    end
  end

  rdc_window #(
    .MAX_LAG(MAX_LAG)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .step_i   (adv),
    .action_i (action_q),
    .yaw_i    (yaw_q),
    .dir_o    (dir),
    .decided_o(decided)
  );

  assign out_valid_o = out_valid_q;
  assign direction_o = direction_q;
  assign decided_o = decided_q;
  assign locked_o = direction_q[1];

endmodule
